>>> rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared widths, constants and the arctangent table for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;

    localparam int STEP_W  = $clog2(CORDIC_STEPS + 1);
    // Low bits of the turn product that decide the heading step and half step.
    localparam int TURN_SH = 40 - ANGLE_BITS;
    localparam int TURN_W  = TURN_SH + ANGLE_BITS + 1;

    localparam int TRIG_W  = 34;
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 30;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int DVD_W   = 57;

    localparam logic [TRIG_W-1:0] CORDIC_GAIN   = TRIG_W'(652032874);
    localparam logic [21:0]       INV_TWO_PI    = 22'd2670177;
    localparam logic [19:0]       US_PER_S      = 20'd1000000;
    localparam logic [DVD_W-1:0]  HALF_US_PER_S = DVD_W'(500000);

    // floor(2^60 / 1e6): estimates the quotient from the top 29 dividend bits.
    localparam logic [40:0]       DIV_RECIP     = 41'd1152921504606;
    // ceil(2^49 / 1e6): exact quotient for any remainder below 2^29.
    localparam logic [29:0]       DIV_RECIP2    = 30'd562949954;

    localparam logic [15:0] VU_RESET = 16'd5024;
    localparam logic [15:0] WR_RESET = 16'd1999;
    localparam logic [23:0] IB_RESET = 24'd273067;

    typedef enum logic [1:0] {
        REG_VELOCITY_UNIT = 2'd0,
        REG_WHEEL_RADIUS  = 2'd1,
        REG_INV_BASE      = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_index;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: one shift-add step per cycle, cos and sin
// of a 32-bit turn angle in Q4.30 after quadrant reduction.
// ----------------------------------------------------------------------------
module ddo_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [31:0]                        i_angle,
    output logic                               o_done,
    output logic signed [ddo_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [ddo_pkg::TRIG_W-1:0]  o_sin
);
    import ddo_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_i;
    logic [1:0]               r_q;
    logic signed [TRIG_W-1:0] r_x;
    logic signed [TRIG_W-1:0] r_y;
    logic signed [32:0]       r_z;

    logic [1:0]               start_q;
    logic [31:0]              resid;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [32:0]       atan_s;

    always_comb begin
        start_q = 2'((i_angle + 32'h2000_0000) >> 30);
        resid   = i_angle - {start_q, 30'd0};
        dx      = r_y >>> r_i;
        dy      = r_x >>> r_i;
        atan_s  = $signed({1'b0, atan_turn(5'(r_i))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_i == STEP_W'(CORDIC_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_q    <= start_q;
                r_x    <= $signed(CORDIC_GAIN);
                r_y    <= '0;
                r_z    <= $signed({resid[31], resid});
            end else if (r_busy) begin
                if (!r_z[32]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_s;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_s;
                end
                r_i <= r_i + 1'b1;
                if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        case (r_q)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

>>> rtl/differential_drive_odometry.sv
// Sequencing: an input transfer runs the sequencer steps around one shared
// multiplier, two of them four-step divisions by one million, then the
// 16-step CORDIC with its start and finish, before a valid result appears.
// The input is not ready while an item is in work, and a result that is not
// taken stalls the block in its last step.
// Reset (synchronous, active low) clears position, heading, output valid; restores registers.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry: wheel speeds to body speeds, dead-reckoned x, y and heading,
// sequenced through one shared multiplier; divisions use reciprocals.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] left_raw_velocity, [31:16] right_raw_velocity, [47:32] elapsed_us
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [79:64] yaw, [111:80] linear_speed,
    // [143:112] turn_rate
    output logic [143:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_WL, S_WR, S_VL, S_VR, S_VSUM, S_W, S_DSM, S_DSD,
        S_DQ0, S_DQ1, S_DQ2, S_DQ3,
        S_DSQ, S_WD, S_WQ, S_TURN, S_ANG, S_CWAIT, S_MX, S_MY, S_OUT
    } t_state;

    t_state r_state;

    logic [15:0] r_vu, r_rad;
    logic [23:0] r_ib;
    logic [14:0] r_ml, r_mr;
    logic        r_sl, r_sr;
    logic [15:0] r_us;
    logic signed [31:0]         r_wl, r_wr, r_vl, r_v;
    logic signed [32:0]         r_diff;
    logic signed [40:0]         r_w;
    logic signed [28:0]         r_ds;
    logic signed [MUL_A_W-1:0]  r_dth;
    logic signed [PROD_W-1:0]   r_prod;
    logic [DVD_W-1:0]           r_dvd;
    logic [37:0]                r_qe;
    logic                       r_sel_w;
    logic [ANGLE_BITS-1:0]      r_head, r_dang;
    logic [31:0]                r_angle;
    logic                       r_cstart;
    logic signed [31:0]         r_xn;
    logic signed [31:0]         r_x, r_y;
    logic                       r_ovalid;
    logic [143:0]               r_odata;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic                       mul_en;
    logic signed [31:0]         vr;
    logic [31:0]                v_mag;
    logic [40:0]                w_mag;
    logic [29:0]                div_rem;
    logic [TURN_W-1:0]          turns, t_dang, t_half;
    logic [ANGLE_BITS-1:0]      mid;
    logic [ANGLE_BITS-1:0]      n_head;
    logic                       c_done;
    logic signed [TRIG_W-1:0]   c_cos, c_sin;
    logic signed [42:0]         pos_x_sum, pos_y_sum;
    logic signed [31:0]         pos_y_new, turn_sat;
    logic [15:0]                yaw16;

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] r;
        if (v > 43'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -43'sd2147483648) r = 32'sh8000_0000;
        else                           r = 32'(v);
        return r;
    endfunction

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (r_angle),
        .o_done  (c_done),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_WL: begin
                mul_a = $signed(MUL_A_W'(r_ml));
                mul_b = $signed(MUL_B_W'(r_vu));
            end
            S_WR: begin
                mul_a = $signed(MUL_A_W'(r_mr));
                mul_b = $signed(MUL_B_W'(r_vu));
            end
            S_VL: begin
                mul_a = MUL_A_W'(r_wl);
                mul_b = $signed(MUL_B_W'(r_rad));
            end
            S_VR: begin
                mul_a = MUL_A_W'(r_wr);
                mul_b = $signed(MUL_B_W'(r_rad));
            end
            S_W: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = $signed(MUL_B_W'(r_ib));
            end
            S_DSM: begin
                mul_a = $signed(MUL_A_W'(v_mag));
                mul_b = $signed(MUL_B_W'(r_us));
            end
            // Quotient estimate from the top dividend bits; it is low by at
            // most a few hundred.
            S_DQ0: begin
                mul_a = $signed(MUL_A_W'(DIV_RECIP));
                mul_b = $signed(MUL_B_W'(r_dvd[DVD_W-1:28]));
            end
            S_DQ1: begin
                mul_a = $signed(MUL_A_W'(r_prod[69:32]));
                mul_b = $signed(MUL_B_W'(US_PER_S));
            end
            // The remainder left by the estimate is divided exactly.
            S_DQ2: begin
                mul_a = $signed(MUL_A_W'(DIV_RECIP2));
                mul_b = $signed(MUL_B_W'(div_rem[28:0]));
            end
            S_DSQ: begin
                mul_a = $signed(MUL_A_W'(w_mag));
                mul_b = $signed(MUL_B_W'(r_us));
            end
            S_TURN: begin
                mul_a = r_dth;
                mul_b = $signed(MUL_B_W'(INV_TWO_PI));
            end
            S_MX: begin
                mul_a = MUL_A_W'(c_cos);
                mul_b = MUL_B_W'(r_ds);
            end
            S_MY: begin
                mul_a = MUL_A_W'(c_sin);
                mul_b = MUL_B_W'(r_ds);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb begin
        vr      = r_prod[47:16];
        v_mag   = r_v[31] ? 32'(-r_v) : 32'(r_v);
        w_mag   = r_w[40] ? 41'(-r_w) : 41'(r_w);
        div_rem = r_dvd[29:0] - r_prod[29:0];
        turns   = r_prod[TURN_W-1:0];
        // Rounding offsets: nearest for the step, nearest at half resolution.
        t_dang = turns + (TURN_W'(1) << (TURN_SH - 1));
        t_half = turns + (TURN_W'(1) << TURN_SH);
        mid    = r_head + t_half[TURN_W-1 -: ANGLE_BITS];
        n_head = r_head + r_dang;
        pos_x_sum = 43'(r_x) + 43'($signed(r_prod[PROD_W-1:30]));
        pos_y_sum = 43'(r_y) + 43'($signed(r_prod[PROD_W-1:30]));
        pos_y_new = sat32(pos_y_sum);
        turn_sat  = sat32(43'(r_w));
    end

    generate
        if (ANGLE_BITS >= 16) begin : g_yaw_hi
            assign yaw16 = n_head[ANGLE_BITS-1 -: 16];
        end else begin : g_yaw_lo
            assign yaw16 = {n_head, (16 - ANGLE_BITS)'(0)};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vu     <= VU_RESET;
            r_rad    <= WR_RESET;
            r_ib     <= IB_RESET;
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
            r_cstart <= 1'b0;
        end else begin
            r_cstart <= (r_state == S_ANG);
            if (mul_en) begin
                r_prod <= mul_a * mul_b;
            end
            // A result leaving while the next one is written is handled in S_OUT.
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (t_reg_index'(i_cfg_index))
                    REG_VELOCITY_UNIT: r_vu  <= i_cfg_data[15:0];
                    REG_WHEEL_RADIUS:  r_rad <= i_cfg_data[15:0];
                    REG_INV_BASE:      r_ib  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ml    <= s_axis_tdata[14:0];
                        r_sl    <= s_axis_tdata[15];
                        r_mr    <= s_axis_tdata[30:16];
                        r_sr    <= s_axis_tdata[31];
                        r_us    <= s_axis_tdata[47:32];
                        r_state <= S_WL;
                    end
                end
                S_WL: r_state <= S_WR;
                S_WR: begin
                    r_wl    <= r_sl ? -32'(r_prod) : 32'(r_prod);
                    r_state <= S_VL;
                end
                S_VL: begin
                    // The right wheel is mounted mirrored, so its sign flips.
                    r_wr    <= r_sr ? 32'(r_prod) : -32'(r_prod);
                    r_state <= S_VR;
                end
                S_VR: begin
                    r_vl    <= r_prod[47:16];
                    r_state <= S_VSUM;
                end
                S_VSUM: begin
                    r_v     <= 32'((33'(vr) + 33'(r_vl)) >>> 1);
                    r_diff  <= 33'(vr) - 33'(r_vl);
                    r_state <= S_W;
                end
                S_W: r_state <= S_DSM;
                S_DSM: begin
                    r_w     <= r_prod[56:16];
                    r_state <= S_DSD;
                end
                S_DSD: begin
                    r_dvd   <= r_prod[DVD_W-1:0] + HALF_US_PER_S;
                    r_sel_w <= 1'b0;
                    r_state <= S_DQ0;
                end
                S_DQ0: r_state <= S_DQ1;
                S_DQ1: begin
                    r_qe    <= r_prod[69:32];
                    r_state <= S_DQ2;
                end
                S_DQ2: r_state <= S_DQ3;
                S_DQ3: begin
                    r_dvd   <= DVD_W'(r_qe) + DVD_W'(r_prod[58:49]);
                    r_state <= r_sel_w ? S_WQ : S_DSQ;
                end
                S_DSQ: begin
                    r_ds    <= r_v[31] ? -29'(r_dvd) : 29'(r_dvd);
                    r_state <= S_WD;
                end
                S_WD: begin
                    r_dvd   <= r_prod[DVD_W-1:0] + HALF_US_PER_S;
                    r_sel_w <= 1'b1;
                    r_state <= S_DQ0;
                end
                S_WQ: begin
                    r_dth   <= r_w[40] ? -MUL_A_W'(r_dvd) : MUL_A_W'(r_dvd);
                    r_state <= S_TURN;
                end
                S_TURN: r_state <= S_ANG;
                S_ANG: begin
                    r_dang   <= t_dang[TURN_W-2 -: ANGLE_BITS];
                    r_angle  <= {mid, (32 - ANGLE_BITS)'(0)};
                    r_state  <= S_CWAIT;
                end
                S_CWAIT: begin
                    if (c_done) begin
                        r_state <= S_MX;
                    end
                end
                S_MX: r_state <= S_MY;
                S_MY: begin
                    r_xn    <= sat32(pos_x_sum);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_x      <= r_xn;
                        r_y      <= pos_y_new;
                        r_head   <= n_head;
                        r_ovalid <= 1'b1;
                        r_odata  <= {turn_sat, r_v, yaw16, pos_y_new, r_xn};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign o_cfg_ready   = 1'b1;

endmodule

>>> rtl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);
    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // A new result only appears at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not clear the handshake");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
